// ===== hw/rtl/ripq_pkg.sv =====
package ripq_pkg;

  // Longest bit string held, and the widths that follow from it.
  localparam int MAX_LEN    = 1024;
  localparam int POS_W      = 11;
  localparam int WALK_W     = POS_W + 1;
  localparam int BIT_AW     = $clog2(MAX_LEN);
  localparam int NLEV       = $clog2(MAX_LEN) + 1;
  localparam int LVL_W      = $clog2(NLEV);
  localparam int CELL_DEPTH = MAX_LEN / 2;
  localparam int CELL_AW    = $clog2(CELL_DEPTH);

  localparam logic [POS_W-1:0] LEN_RESET = POS_W'(MAX_LEN);

  // Input actions.
  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_INVERT = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  // Kind of walk a token performs through the cell chain.
  typedef enum logic {
    WALK_TOGGLE = 1'b0,
    WALK_QUERY  = 1'b1
  } walk_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_LAUNCH2,
    ST_QWAIT,
    ST_DELIVER,
    ST_DRAIN,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    act_t             action;
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] right;
    logic             load_bit;
  } in_data_t;

  typedef struct packed {
    logic bit_value;
    logic bad_position;
  } out_data_t;

  // One walk travelling down the chain of tree levels.
  typedef struct packed {
    logic              valid;
    walk_op_t          op;
    logic [WALK_W-1:0] pos;
    logic              acc;
  } tok_t;

  // Clearing pass control shared by all cells.
  typedef struct packed {
    logic               active;
    logic [CELL_AW-1:0] idx;
  } clr_t;

endpackage

// ===== hw/rtl/ripq_cell.sv =====
module ripq_cell import ripq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [LVL_W-1:0]  lvl,
  input  logic [WALK_W-1:0] len,
  input  clr_t              clr,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  // Tree nodes whose lowest set bit is this cell's level.
  logic               mem [CELL_DEPTH];
  tok_t               tok_r;
  logic               hit_r;
  logic [CELL_AW-1:0] addr_r;
  logic               rd_r;

  logic [WALK_W-1:0]  bit_k;
  logic [WALK_W-1:0]  low_mask;
  logic               in_hit;
  logic [CELL_AW-1:0] in_addr;
  logic               wr_en;

  // The walk visits this level only when the position's lowest set bit is here.
  assign bit_k    = WALK_W'(1) << lvl;
  assign low_mask = (bit_k << 1) - WALK_W'(1);
  assign in_hit   = tok_in.valid && ((tok_in.pos & low_mask) == bit_k) &&
                    (tok_in.op == WALK_QUERY || tok_in.pos <= len);
  assign in_addr  = CELL_AW'(tok_in.pos >> (lvl + 1'b1));
  assign wr_en    = tok_r.valid && hit_r && (tok_r.op == WALK_TOGGLE);

  // Token stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  // Read address and hit flag travel with the token.
  always_ff @(posedge clk) begin
    hit_r  <= in_hit;
    addr_r <= in_addr;
  end

  // Node storage: clearing pass, toggle write-back, and a read that bypasses
  // the write of the token ahead when both touch the same node.
  always_ff @(posedge clk) begin
    if (clr.active) begin
      mem[clr.idx] <= 1'b0;
    end else if (wr_en) begin
      mem[addr_r] <= ~rd_r;
    end
    if (wr_en && addr_r == in_addr) begin
      rd_r <= ~rd_r;
    end else begin
      rd_r <= mem[in_addr];
    end
  end

  // Step the walk to the next node.
  always_comb begin
    tok_out = tok_r;
    if (hit_r) begin
      if (tok_r.op == WALK_TOGGLE) begin
        tok_out.pos = tok_r.pos + bit_k;
      end else begin
        tok_out.pos = tok_r.pos - bit_k;
        tok_out.acc = tok_r.acc ^ rd_r;
      end
    end
  end

endmodule

// ===== hw/rtl/range_invert_point_query_bits_top.sv =====
// Channel   Handshake               Payload
// in        in_valid / in_ready     in_data  (action, left, right, load_bit)
// out       out_valid / out_ready   out_data (bit_value, bad_position)
// cfg       cfg_valid / cfg_ready   cfg_data (length_in_use)
//
// A load completes in idle; an invert launches toggle walks from ST_LAUNCH and
// ST_LAUNCH2; neither gives a result. A query walks the 11 tree-level cells
// one per cycle; its result beat goes to the output register, and the next
// item is then taken. A clear waits for walks in flight, then zeroes all 512
// nodes in each cell memory in a pass; reset starts with the same pass.
// A stalled result sits in the output register while the next item is taken.
module range_invert_point_query_bits_top import ripq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_data_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_data_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_data
);

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   len_r;
  in_data_t           item_r, item_nxt;
  logic [CELL_AW-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_data_t          out_data_r, out_data_nxt;
  out_data_t          hold_r, hold_nxt;
  logic               bits_mem [MAX_LEN];
  logic               bits_rd_r;

  logic [WALK_W-1:0]  eff_len;
  logic               in_fire;
  logic               in_left_ok;
  logic               item_left_ok;
  logic [WALK_W-1:0]  right_p1;
  logic               right_ok;
  logic               res_avail;
  out_data_t          res_val;
  logic               out_free;
  clr_t               clr;
  tok_t               launch_tok;
  tok_t               chain [NLEV+1];

  // Effective length: zero acts as one, beyond the maximum acts as the maximum.
  always_comb begin
    if (len_r == '0) begin
      eff_len = WALK_W'(1);
    end else if (len_r > LEN_RESET) begin
      eff_len = WALK_W'(MAX_LEN);
    end else begin
      eff_len = WALK_W'(len_r);
    end
  end

  assign cfg_ready = 1'b1;

  // Length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_valid) begin
      len_r <= cfg_data;
    end
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign in_left_ok   = (in_data.left != '0) && (WALK_W'(in_data.left) <= eff_len);
  assign item_left_ok = (item_r.left != '0) && (WALK_W'(item_r.left) <= eff_len);
  assign right_p1     = WALK_W'(item_r.right) + WALK_W'(1);
  assign right_ok     = right_p1 <= eff_len;
  assign out_free     = !out_valid_r || out_ready;

  // Original bit store: written by loads, read in ST_LAUNCH for the query result.
  always_ff @(posedge clk) begin
    if (in_fire && in_data.action == ACT_LOAD && in_left_ok) begin
      bits_mem[BIT_AW'(in_data.left - 1'b1)] <= in_data.load_bit;
    end
    if (state_r == ST_LAUNCH) begin
      bits_rd_r <= bits_mem[BIT_AW'(item_r.left - 1'b1)];
    end
  end

  // Sequencer: launches walks, collects query results, runs the clearing pass.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    launch_tok    = '0;
    clr.active    = 1'b0;
    clr.idx       = cnt_r;
    res_avail     = 1'b0;
    res_val       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          case (in_data.action)
            ACT_INVERT, ACT_QUERY: state_nxt = ST_LAUNCH;
            ACT_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = ST_DRAIN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LAUNCH: begin
        if (item_r.action == ACT_INVERT) begin
          launch_tok.valid = item_left_ok;
          launch_tok.op    = WALK_TOGGLE;
          launch_tok.pos   = WALK_W'(item_r.left);
          state_nxt        = ST_LAUNCH2;
        end else if (item_left_ok) begin
          launch_tok.valid = 1'b1;
          launch_tok.op    = WALK_QUERY;
          launch_tok.pos   = WALK_W'(item_r.left);
          state_nxt        = ST_QWAIT;
        end else begin
          res_avail              = 1'b1;
          res_val.bit_value      = 1'b0;
          res_val.bad_position   = 1'b1;
        end
      end
      ST_LAUNCH2: begin
        launch_tok.valid = right_ok;
        launch_tok.op    = WALK_TOGGLE;
        launch_tok.pos   = right_p1;
        state_nxt        = ST_IDLE;
      end
      ST_QWAIT: begin
        if (chain[NLEV].valid && chain[NLEV].op == WALK_QUERY) begin
          res_avail            = 1'b1;
          res_val.bit_value    = bits_rd_r ^ chain[NLEV].acc;
          res_val.bad_position = 1'b0;
        end
      end
      ST_DELIVER: begin
        res_avail = 1'b1;
        res_val   = hold_r;
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CELL_AW'(NLEV)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        clr.active = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CELL_AW'(CELL_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Hand a finished result to the output register, or hold it.
    if (res_avail) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_val;
        state_nxt     = ST_IDLE;
      end else begin
        hold_nxt  = res_val;
        state_nxt = ST_DELIVER;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The sequencer feeds the first cell of the chain.
  assign chain[0] = launch_tok;

  // Chain of tree-level cells, lowest set bit 1 first.
  for (genvar k = 0; k < NLEV; k++) begin : g_cell
    ripq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .lvl     (LVL_W'(k)),
      .len     (eff_len),
      .clr     (clr),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

endmodule

// ===== dv/bit_string_checker.sv =====
`timescale 1ns / 1ps

module bit_string_checker import ripq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_data_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_data_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_data,
  output int               mismatch_total,
  output int               answers_due
);

  // Our own copy of the length register, the stored string and the parity tree.
  logic [POS_W-1:0] length_reg;
  bit   [MAX_LEN:1] stored_bits;
  bit   [MAX_LEN:1] toggle_tree;
  out_data_t        query_answers[$];
  int               answers_seen;

  // The register value clamped into 1..MAX_LEN.
  function automatic int unsigned live_length();
    if (length_reg == '0) return 1;
    if (32'(length_reg) > MAX_LEN) return MAX_LEN;
    return 32'(length_reg);
  endfunction

  // Toggle every tree cell that covers pos; pos 0 and positions past n do nothing.
  function automatic void flip_path(input int unsigned pos, input int unsigned n);
    if (pos == 0) return;
    while (pos <= n) begin
      toggle_tree[pos] ^= 1'b1;
      pos += pos & (~pos + 1);
    end
  endfunction

  // Number of inversions covering pos, modulo 2.
  function automatic bit prefix_parity(input int unsigned pos);
    bit acc;
    acc = 1'b0;
    while (pos > 0) begin
      acc ^= toggle_tree[pos];
      pos -= pos & (~pos + 1);
    end
    return acc;
  endfunction

  // Update the mirrored state for one accepted item and queue the answer of a query.
  function automatic void apply_item(input in_data_t d);
    int unsigned n;
    int unsigned l;
    int unsigned r;
    out_data_t   ans;
    n = live_length();
    l = 32'(d.left);
    r = 32'(d.right);
    case (d.action)
      ACT_LOAD: begin
        if (l >= 1 && l <= n) stored_bits[l] = d.load_bit;
      end
      ACT_INVERT: begin
        if (l <= n) flip_path(l, n);
        flip_path(r + 1, n);
      end
      ACT_QUERY: begin
        if (l < 1 || l > n) begin
          ans.bit_value    = 1'b0;
          ans.bad_position = 1'b1;
        end else begin
          ans.bit_value    = stored_bits[l] ^ prefix_parity(l);
          ans.bad_position = 1'b0;
        end
        query_answers.push_back(ans);
      end
      ACT_CLEAR: begin
        toggle_tree = '0;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_wrong(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_total++;
  endtask

  // Compare one result beat against the oldest outstanding answer.
  task automatic check_answer(input out_data_t got);
    out_data_t want;
    answers_seen++;
    if (query_answers.size() == 0) begin
      report_wrong($sformatf("result %0d arrived with no query waiting", answers_seen));
    end else begin
      want = query_answers.pop_front();
      if (got.bit_value !== want.bit_value)
        report_wrong($sformatf("result %0d: bit_value is %b, should be %b",
                               answers_seen, got.bit_value, want.bit_value));
      if (got.bad_position !== want.bad_position)
        report_wrong($sformatf("result %0d: bad_position is %b, should be %b",
                               answers_seen, got.bad_position, want.bad_position));
    end
  endtask

  // Watch all three channels at every clock edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      length_reg  = LEN_RESET;
      stored_bits = '0;
      toggle_tree = '0;
      query_answers.delete();
      answers_seen = 0;
      answers_due <= 0;
    end else begin
      if (cfg_valid && cfg_ready) length_reg = cfg_data;
      if (in_valid && in_ready) apply_item(in_data);
      if (out_valid && out_ready) check_answer(out_data);
      answers_due <= query_answers.size();
    end
  end

endmodule

// ===== dv/tb_range_invert_point_query_bits_top.sv =====
`timescale 1ns / 1ps

module tb_range_invert_point_query_bits_top;
  import ripq_pkg::*;

  localparam int          POS_TOP        = 2**POS_W - 1;
  localparam int          PHASE_ITEMS    = 58;
  // A clear waits for walks in flight and then sweeps 512 addresses in every cell.
  localparam int          DRAIN_CYCLES   = 600;
  localparam int          LONG_HOLD      = 300;
  localparam int          QUIET_LIMIT    = 5000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_data_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_data_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [POS_W-1:0] cfg_data  = '0;

  int               mismatch_total;
  int               answers_due;
  int               beats_offered;
  int               quiet_cycles;
  int unsigned      span = MAX_LEN;
  bit [POS_TOP:0]   seen_pos;
  int unsigned      seen_list[$];
  bit               held_early;
  bit               held_late;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  range_invert_point_query_bits_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bit_string_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_total (mismatch_total),
    .answers_due    (answers_due)
  );

  function automatic in_data_t make_item(act_t a, int unsigned l, int unsigned r, bit b);
    in_data_t d;
    d.action   = a;
    d.left     = POS_W'(l);
    d.right    = POS_W'(r);
    d.load_bit = b;
    return d;
  endfunction

  function automatic int unsigned any_pos();
    return $urandom_range(0, POS_TOP);
  endfunction

  // A position the block must reject under the current length.
  function automatic int unsigned stray_pos();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(span + 1, POS_TOP);
  endfunction

  // Offer one input beat after a random gap, and hold it until it is taken.
  task automatic offer_beat(input in_data_t d);
    int unsigned gap;
    gap = ((beats_offered / 40) % 4 == 3) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    beats_offered++;
  endtask

  // A load; positions that land inside the string become safe to query.
  task automatic load_at(input int unsigned p, input bit b);
    offer_beat(make_item(ACT_LOAD, p, any_pos(), b));
    if (p >= 1 && p <= span && !seen_pos[p]) begin
      seen_pos[p] = 1'b1;
      seen_list.push_back(p);
    end
  endtask

  task automatic ask(input int unsigned p);
    offer_beat(make_item(ACT_QUERY, p, any_pos(), 1'($urandom_range(0, 1))));
  endtask

  task automatic invert(input int unsigned l, input int unsigned r);
    offer_beat(make_item(ACT_INVERT, l, r, 1'($urandom_range(0, 1))));
  endtask

  task automatic clear_tree();
    offer_beat(make_item(ACT_CLEAR, any_pos(), any_pos(), 1'($urandom_range(0, 1))));
  endtask

  // Stop offering, let every answer come back, then give a clear time to finish.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (answers_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [POS_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    span = (v == '0) ? 1 : ((32'(v) > MAX_LEN) ? MAX_LEN : 32'(v));
  endtask

  // One random item; in-range queries only touch positions that were loaded.
  task automatic send_random();
    int unsigned pick;
    int unsigned kind;
    int unsigned l;
    int unsigned r;
    int unsigned tries;
    bit          found;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 9);
    if (pick < 2) begin
      clear_tree();
    end else if (pick < 32) begin
      l = (kind == 0) ? stray_pos() : $urandom_range(1, span);
      load_at(l, 1'($urandom_range(0, 1)));
    end else if (pick < 62) begin
      l = $urandom_range(1, span);
      r = $urandom_range(1, span);
      if (kind == 0) begin
        l = any_pos();
        r = any_pos();
      end else if (kind == 1) begin
        if (l < r) {l, r} = {r, l};
      end else if (kind == 2) begin
        r = span;
      end else if (l > r) begin
        {l, r} = {r, l};
      end
      invert(l, r);
    end else if (kind == 0) begin
      ask(stray_pos());
    end else begin
      found = 1'b0;
      tries = 0;
      while (!found && tries < 8 && seen_list.size() > 0) begin
        l = seen_list[$urandom_range(0, seen_list.size() - 1)];
        found = (l <= span);
        tries++;
      end
      if (found) ask(l);
      else load_at($urandom_range(1, span), 1'($urandom_range(0, 1)));
    end
  endtask

  // Result side: random stalls, calm stretches, and two long holds mid-stream.
  initial begin : result_sink
    int unsigned gap;
    int          results_taken;
    results_taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held_early && beats_offered >= 150) begin
        gap = LONG_HOLD;
        held_early = 1'b1;
      end else if (!held_late && beats_offered >= 400) begin
        gap = LONG_HOLD;
        held_late = 1'b1;
      end else if ((results_taken / 25) % 4 == 2) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  // End the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus: directed corner cases at the reset length, then random phases.
  initial begin : stimulus
    logic [POS_W-1:0] lengths[9];
    lengths = '{11'd0, 11'd2047, 11'd9, 11'd1, 11'd64, 11'd1023, 11'd5, 11'd300, 11'd1024};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Loads at both ends, plus loads that fall outside the string.
    load_at(1, 1'b1);
    load_at(2, 1'b0);
    load_at(3, 1'b1);
    load_at(4, 1'b0);
    load_at(MAX_LEN, 1'b1);
    load_at(0, 1'b1);
    load_at(POS_TOP, 1'b0);
    ask(1);
    ask(MAX_LEN);
    ask(0);
    ask(MAX_LEN + 1);

    // Whole-string inversion: the toggle past the end is skipped.
    invert(1, MAX_LEN);
    ask(1);
    ask(MAX_LEN);

    // Reversed range inverts the positions between right and left.
    invert(5, 1);
    ask(2);
    ask(4);
    invert(3, 2);
    ask(3);

    // Left outside the string: only the toggle after right remains, if it lies in the string.
    invert(0, POS_TOP);
    invert(POS_TOP, 0);
    ask(1);

    // A clear drops the inversions but keeps the loaded bits.
    clear_tree();
    ask(3);
    ask(2);

    foreach (lengths[i]) begin
      settle();
      write_length(lengths[i]);
      repeat (PHASE_ITEMS) send_random();
    end
    settle();

    if (mismatch_total == 0 && answers_due == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ripq_pkg.sv
hw/rtl/ripq_cell.sv
hw/rtl/range_invert_point_query_bits_top.sv
dv/bit_string_checker.sv
dv/tb_range_invert_point_query_bits_top.sv
